FILE: rtl/core/hcbp_pkg.sv
// Package for the Huffman code bit packer core.
// Holds widths, operation and result-kind codes, sequencer states and the table request type.
// No dependencies.
`default_nettype none

package hcbp_pkg;

	localparam int CODE_W        = 32;
	localparam int MAX_CODE_BITS = 32;
	localparam int LEN_LIMIT     = (MAX_CODE_BITS < CODE_W) ? MAX_CODE_BITS : CODE_W;
	localparam int SYM_W         = 8;
	localparam int LEN_W         = 6;
	localparam int BYTE_W        = 8;
	localparam int CNT_W         = 3;
	localparam int ACC_W         = BYTE_W + CODE_W;
	localparam int REM_W         = 6;
	localparam int TBL_DEPTH     = 1 << SYM_W;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_PADDED = 2'd1,
		KIND_PADCNT = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BUILD,
		ST_EMIT,
		ST_FLUSH_BYTE,
		ST_FLUSH_PAD
	} state_t;

	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [SYM_W-1:0]  addr;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} tbl_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/hcbp_in_if.sv
// Input channel of the Huffman code bit packer: valid/ready and one operation per transaction.
// Depends on hcbp_pkg for field widths.
`default_nettype none

interface hcbp_in_if import hcbp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        opcode;
	logic [SYM_W-1:0]  symbol;
	logic [CODE_W-1:0] entry_code;
	logic [LEN_W-1:0]  entry_length;

	modport source (output valid, opcode, symbol, entry_code, entry_length, input ready);
	modport sink (input valid, opcode, symbol, entry_code, entry_length, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hcbp_out_if.sv
// Output channel of the Huffman code bit packer: valid/ready and one result byte per transaction.
// Depends on hcbp_pkg for field widths.
`default_nettype none

interface hcbp_out_if import hcbp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic [1:0]        byte_kind;
	logic              last;

	modport source (output valid, out_byte, byte_kind, last, input ready);
	modport sink (input valid, out_byte, byte_kind, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/hcbp_table.sv
// Code and length table of the Huffman code bit packer, 256 entries with registered read.
// Lengths read as zero until written; depends on hcbp_pkg.
`default_nettype none

module hcbp_table import hcbp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tbl_req_t          req,
	output logic      [CODE_W-1:0] rd_code,
	output logic      [LEN_W-1:0]  rd_len
);

	logic [CODE_W-1:0]    code_mem [TBL_DEPTH];
	logic [LEN_W-1:0]     len_mem  [TBL_DEPTH];
	logic [TBL_DEPTH-1:0] vld_q;
	logic [CODE_W-1:0]    code_q;
	logic [LEN_W-1:0]     len_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			code_mem[req.addr] <= req.code;
			len_mem[req.addr]  <= req.len;
		end
		if (req.rd_en) begin
			code_q <= code_mem[req.addr];
			len_q  <= len_mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.addr];
			end
		end
	end

	assign rd_code = code_q;
	assign rd_len  = rd_vld_q ? len_q : '0;

endmodule

`default_nettype wire

FILE: rtl/core/huffman_code_bit_packer_core.sv
// Top level of the Huffman code bit packer: sequencer, byte accumulator and shifter.
// Depends on hcbp_pkg, hcbp_in_if, hcbp_out_if and hcbp_table.
//
//   Channel  Role    Transaction
//   item     sink    one load, encode or flush operation
//   result   source  one packed byte, padded final byte or pad count
//
// A load writes its table entry when accepted. An encode reads the table, then makes one pass
// through the 40-bit shifter, then emits each full byte, one per cycle while the result is taken.
// A flush emits the padded final byte, then the pad count. The item channel
// is ready only while the sequencer is idle; a stalled result holds the sequencer in place.
// Reset clears the pending bits and all table lengths at once.
`default_nettype none

module huffman_code_bit_packer_core import hcbp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	hcbp_in_if.sink   item,
	hcbp_out_if.source result
);

	state_t             state_q;
	state_t             state_nx;
	logic [BYTE_W-1:0]  pend_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ACC_W-1:0]   acc_q;
	logic [REM_W-1:0]   rem_q;

	tbl_req_t           tbl_req;
	logic [CODE_W-1:0]  rd_code;
	logic [LEN_W-1:0]   rd_len;

	logic               in_acc;
	logic               out_acc;
	logic [LEN_W-1:0]   len_sat;
	logic [REM_W-1:0]   total;
	logic [LEN_W-1:0]   shamt;
	logic [ACC_W-1:0]   code_al;
	logic [ACC_W-1:0]   acc_nx;
	logic               last_data;

	assign in_acc  = item.valid && item.ready;
	assign out_acc = result.valid && result.ready;

	assign len_sat = (item.entry_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT)
		: item.entry_length;

	always_comb begin
		tbl_req.wr_en = in_acc && (item.opcode == OP_LOAD);
		tbl_req.rd_en = in_acc && (item.opcode == OP_ENCODE);
		tbl_req.addr  = item.symbol;
		tbl_req.code  = item.entry_code;
		tbl_req.len   = len_sat;
	end

	hcbp_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (tbl_req),
		.rd_code (rd_code),
		.rd_len  (rd_len)
	);

	// The pending bits are kept left aligned; the code is placed right behind them.
	assign total     = REM_W'(cnt_q) + REM_W'(rd_len);
	assign shamt     = LEN_W'(CODE_W) - rd_len;
	assign code_al   = {rd_code, {BYTE_W{1'b0}}} << shamt;
	assign acc_nx    = {pend_q, {CODE_W{1'b0}}} | (code_al >> cnt_q);
	assign last_data = (rem_q < REM_W'(2 * BYTE_W));

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (item.opcode == OP_ENCODE) begin
						state_nx = ST_BUILD;
					end else if (item.opcode == OP_FLUSH) begin
						state_nx = ST_FLUSH_BYTE;
					end
				end
			end
			ST_BUILD: begin
				if (total >= REM_W'(BYTE_W)) begin
					state_nx = ST_EMIT;
				end else begin
					state_nx = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_acc && last_data) begin
					state_nx = ST_IDLE;
				end
			end
			ST_FLUSH_BYTE: begin
				if (out_acc) begin
					state_nx = ST_FLUSH_PAD;
				end
			end
			ST_FLUSH_PAD: begin
				if (out_acc) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		item.ready       = 1'b0;
		result.valid     = 1'b0;
		result.out_byte  = acc_q[ACC_W-1 -: BYTE_W];
		result.byte_kind = KIND_DATA;
		result.last      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
			end
			ST_BUILD: begin
				item.ready = 1'b0;
			end
			ST_EMIT: begin
				result.valid = 1'b1;
				result.last  = last_data;
			end
			ST_FLUSH_BYTE: begin
				result.valid     = 1'b1;
				result.out_byte  = pend_q;
				result.byte_kind = KIND_PADDED;
			end
			ST_FLUSH_PAD: begin
				result.valid     = 1'b1;
				result.out_byte  = BYTE_W'(BYTE_W) - BYTE_W'(cnt_q);
				result.byte_kind = KIND_PADCNT;
				result.last      = 1'b1;
			end
			default: item.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= '0;
			cnt_q   <= '0;
			acc_q   <= '0;
			rem_q   <= '0;
		end else begin
			state_q <= state_nx;
			unique case (state_q)
				ST_BUILD: begin
					if (total >= REM_W'(BYTE_W)) begin
						acc_q <= acc_nx;
						rem_q <= total;
					end else begin
						pend_q <= acc_nx[ACC_W-1 -: BYTE_W];
						cnt_q  <= CNT_W'(total);
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						acc_q <= acc_q << BYTE_W;
						rem_q <= rem_q - REM_W'(BYTE_W);
						if (last_data) begin
							pend_q <= acc_q[ACC_W-BYTE_W-1 -: BYTE_W];
							cnt_q  <= CNT_W'(rem_q - REM_W'(BYTE_W));
						end
					end
				end
				ST_FLUSH_PAD: begin
					if (out_acc) begin
						pend_q <= '0;
						cnt_q  <= '0;
					end
				end
				default: begin
					rem_q <= rem_q;
				end
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(item.ready && result.valid))
		else $error("item ready while a result is pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & (8'hFF >> cnt_q)) == 8'h00)
		else $error("pending bits below the fill level are not zero");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (rem_q >= REM_W'(BYTE_W)))
		else $error("data byte emitted with fewer than eight bits held");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH_PAD && out_acc) |=> (cnt_q == '0 && state_q == ST_IDLE))
		else $error("pending state not cleared after flush");

endmodule

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the Huffman code bit packer core: directed table, then random traffic.
// A local packing predictor computes the result bytes of untyped rows, typed rows give them directly;
// random stalls and gaps stress both channels. Depends on hcbp_pkg, hcbp_in_if, hcbp_out_if and the core RTL.
`default_nettype none

module tb_top import hcbp_pkg::*; ();

	localparam logic [1:0] OP_UNUSED      = 2'd3;
	localparam int         RANDOM_OPS     = 350;
	localparam int         DRAIN_CYCLES   = 20;
	localparam int         HOLD_CYCLES    = 300;
	localparam int         HOLD_AT_RESULT = 120;
	localparam int         PAUSE_AT_OP    = 180;
	localparam int         TIMEOUT        = 1000000;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		kind_t             kind;
		logic              last;
	} emit_rec_t;

	typedef struct packed {
		logic [1:0]        op;
		logic [SYM_W-1:0]  sym;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
		logic              typed;
		int                ntyp;
		logic [31:0]       tbytes;
		logic [7:0]        tkinds;
	} stim_row_t;

	logic clk;
	logic arst_n;

	hcbp_in_if  item_ch ();
	hcbp_out_if res_ch ();

	huffman_code_bit_packer_core u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(res_ch)
	);

	logic [CODE_W-1:0] code_tbl [TBL_DEPTH];
	logic [LEN_W-1:0]  len_tbl [TBL_DEPTH];
	logic              sym_loaded [TBL_DEPTH];
	logic [SYM_W-1:0]  loaded_syms [$];
	logic [BYTE_W-1:0] acc_bits;
	int                acc_cnt;
	emit_rec_t         emit_queue [$];
	emit_rec_t         step_emits [$];
	stim_row_t         dir_rows [$];
	int                err_count = 0;
	int                result_count = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#TIMEOUT;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic log_error(input string msg);
		err_count++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want) begin
			log_error($sformatf("%s is %0h, expected %0h", name, got, want));
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic huff_pack(input logic [1:0] op, input logic [SYM_W-1:0] sym,
			input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
		int        pad;
		emit_rec_t rec;
		step_emits.delete();
		case (op)
			OP_LOAD: begin
				code_tbl[sym] = code;
				len_tbl[sym] = (int'(len) > LEN_LIMIT) ? LEN_W'(LEN_LIMIT) : len;
				if (!sym_loaded[sym]) begin
					sym_loaded[sym] = 1'b1;
					loaded_syms.push_back(sym);
				end
			end
			OP_ENCODE: begin
				for (int i = int'(len_tbl[sym]); i > 0; i--) begin
					acc_bits = {acc_bits[BYTE_W-2:0], code_tbl[sym][i-1]};
					acc_cnt++;
					if (acc_cnt == BYTE_W) begin
						rec.data = acc_bits;
						rec.kind = KIND_DATA;
						rec.last = 1'b0;
						step_emits.push_back(rec);
						acc_bits = '0;
						acc_cnt = 0;
					end
				end
				if (step_emits.size() > 0) begin
					rec = step_emits.pop_back();
					rec.last = 1'b1;
					step_emits.push_back(rec);
				end
			end
			OP_FLUSH: begin
				pad = BYTE_W - acc_cnt;
				rec.data = acc_bits << pad;
				rec.kind = KIND_PADDED;
				rec.last = 1'b0;
				step_emits.push_back(rec);
				rec.data = BYTE_W'(pad);
				rec.kind = KIND_PADCNT;
				rec.last = 1'b1;
				step_emits.push_back(rec);
				acc_bits = '0;
				acc_cnt = 0;
			end
			default: begin
			end
		endcase
	endtask

	task automatic add_row(input logic [1:0] op, input logic [SYM_W-1:0] sym,
			input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len, input logic typed,
			input int ntyp, input logic [31:0] tbytes, input logic [7:0] tkinds);
		stim_row_t row;
		row.op = op;
		row.sym = sym;
		row.code = code;
		row.len = len;
		row.typed = typed;
		row.ntyp = ntyp;
		row.tbytes = tbytes;
		row.tkinds = tkinds;
		dir_rows.push_back(row);
	endtask

	task automatic idle_for(input int n);
		if (n > 0) begin
			item_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_item(input stim_row_t row);
		emit_rec_t rec;
		item_ch.valid <= 1'b1;
		item_ch.opcode <= row.op;
		item_ch.symbol <= row.sym;
		item_ch.entry_code <= row.code;
		item_ch.entry_length <= row.len;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		huff_pack(row.op, row.sym, row.code, row.len);
		if (row.typed) begin
			for (int k = 0; k < row.ntyp; k++) begin
				rec.data = row.tbytes[31-8*k -: 8];
				rec.kind = kind_t'(row.tkinds[7-2*k -: 2]);
				rec.last = (k == row.ntyp - 1);
				emit_queue.push_back(rec);
			end
		end else begin
			foreach (step_emits[k]) begin
				emit_queue.push_back(step_emits[k]);
			end
		end
	endtask

	initial begin
		stim_row_t row;
		int        accepted_ops;
		int        idx;
		int        r;
		int        rl;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.opcode <= OP_LOAD;
		item_ch.symbol <= '0;
		item_ch.entry_code <= '0;
		item_ch.entry_length <= '0;
		acc_bits = '0;
		acc_cnt = 0;
		for (int i = 0; i < TBL_DEPTH; i++) begin
			code_tbl[i] = '0;
			len_tbl[i] = '0;
			sym_loaded[i] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(OP_FLUSH, 8'h00, 32'h0, 6'd0, 1'b1, 2, 32'h0008_0000,
			{KIND_PADDED, KIND_PADCNT, 4'b0});
		add_row(OP_LOAD, 8'h10, 32'hDEAD_BEEF, 6'd0, 1'b1, 0, 32'h0, 8'h0);
		add_row(OP_ENCODE, 8'h10, 32'h0, 6'd0, 1'b1, 0, 32'h0, 8'h0);
		add_row(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1, 0, 32'h0, 8'h0);
		add_row(OP_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32, 1'b1, 0, 32'h0, 8'h0);
		add_row(OP_ENCODE, 8'hFF, 32'h0, 6'd0, 1'b1, 4, 32'hFFFF_FFFF,
			{KIND_DATA, KIND_DATA, KIND_DATA, KIND_DATA});
		add_row(OP_LOAD, 8'h00, 32'h0, 6'd32, 1'b1, 0, 32'h0, 8'h0);
		add_row(OP_ENCODE, 8'h00, 32'h0, 6'd0, 1'b1, 4, 32'h0000_0000,
			{KIND_DATA, KIND_DATA, KIND_DATA, KIND_DATA});
		add_row(OP_LOAD, 8'h01, 32'hFFFF_FFF0, 6'd63, 1'b0, 0, 32'h0, 8'h0);
		add_row(OP_ENCODE, 8'h01, 32'h0, 6'd0, 1'b0, 0, 32'h0, 8'h0);
		add_row(OP_LOAD, 8'h02, 32'hFFFF_FFFD, 6'd3, 1'b0, 0, 32'h0, 8'h0);
		add_row(OP_ENCODE, 8'h02, 32'h0, 6'd0, 1'b0, 0, 32'h0, 8'h0);
		add_row(OP_FLUSH, 8'h00, 32'h0, 6'd0, 1'b1, 2, 32'hA005_0000,
			{KIND_PADDED, KIND_PADCNT, 4'b0});
		add_row(OP_ENCODE, 8'h02, 32'h0, 6'd0, 1'b0, 0, 32'h0, 8'h0);
		add_row(OP_ENCODE, 8'h01, 32'h0, 6'd0, 1'b0, 0, 32'h0, 8'h0);
		add_row(OP_FLUSH, 8'h55, 32'h0, 6'd0, 1'b0, 0, 32'h0, 8'h0);
		add_row(OP_LOAD, 8'h04, 32'h0000_007F, 6'd7, 1'b0, 0, 32'h0, 8'h0);
		add_row(OP_ENCODE, 8'h04, 32'h0, 6'd0, 1'b0, 0, 32'h0, 8'h0);
		add_row(OP_FLUSH, 8'h00, 32'h0, 6'd0, 1'b1, 2, 32'hFE01_0000,
			{KIND_PADDED, KIND_PADCNT, 4'b0});
		add_row(OP_LOAD, 8'h03, 32'h0000_0001, 6'd1, 1'b0, 0, 32'h0, 8'h0);
		add_row(OP_ENCODE, 8'h04, 32'h0, 6'd0, 1'b0, 0, 32'h0, 8'h0);
		add_row(OP_ENCODE, 8'h03, 32'h0, 6'd0, 1'b0, 0, 32'h0, 8'h0);
		add_row(OP_LOAD, 8'h80, 32'hAAAA_AAAA, 6'd33, 1'b0, 0, 32'h0, 8'h0);
		add_row(OP_ENCODE, 8'h80, 32'h0, 6'd0, 1'b0, 0, 32'h0, 8'h0);
		add_row(OP_FLUSH, 8'h00, 32'h0, 6'd0, 1'b0, 0, 32'h0, 8'h0);

		foreach (dir_rows[i]) begin
			idle_for(pick_gap());
			send_item(dir_rows[i]);
		end

		idx = 0;
		accepted_ops = 0;
		while (accepted_ops < RANDOM_OPS) begin
			if (idx == PAUSE_AT_OP) begin
				item_ch.valid <= 1'b0;
				do @(posedge clk); while (emit_queue.size() != 0);
			end else if ((idx / 40) % 3 != 0) begin
				idle_for(pick_gap());
			end
			row = '0;
			row.code = $urandom();
			row.sym = SYM_W'($urandom_range(0, TBL_DEPTH - 1));
			rl = $urandom_range(0, 99);
			if (rl < 8) begin
				row.len = '0;
			end else if (rl < 65) begin
				row.len = LEN_W'($urandom_range(1, 8));
			end else if (rl < 85) begin
				row.len = LEN_W'($urandom_range(9, 24));
			end else if (rl < 95) begin
				row.len = LEN_W'($urandom_range(25, 32));
			end else begin
				row.len = LEN_W'($urandom_range(33, 63));
			end
			r = $urandom_range(0, 99);
			if (r < 20) begin
				row.op = OP_LOAD;
			end else if (r < 84) begin
				row.op = OP_ENCODE;
				row.sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
			end else if (r < 96) begin
				row.op = OP_FLUSH;
			end else begin
				row.op = OP_UNUSED;
			end
			send_item(row);
			if (row.op != OP_UNUSED) begin
				accepted_ops++;
			end
			idx++;
		end
		item_ch.valid <= 1'b0;

		while (emit_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		int        stall_left;
		int        cyc;
		bit        held;
		emit_rec_t want;
		stall_left = 0;
		cyc = 0;
		held = 1'b0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (arst_n && res_ch.valid && res_ch.ready) begin
				result_count++;
				if (emit_queue.size() == 0) begin
					log_error($sformatf("unexpected transaction: byte %0h kind %0d",
						res_ch.out_byte, res_ch.byte_kind));
				end else begin
					want = emit_queue.pop_front();
					check_field("out_byte", int'(res_ch.out_byte), int'(want.data));
					check_field("byte_kind", int'(res_ch.byte_kind), int'(want.kind));
					check_field("last", int'(res_ch.last), int'(want.last));
				end
			end
			if (!held && result_count == HOLD_AT_RESULT) begin
				held = 1'b1;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && ((cyc / 150) % 4) != 0) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire
